### src/pidbc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PID back-calculation unit package
// Beat types, register indexes, saturation codes and divider sizing shared
// by the controller and its divider.
// ----------------------------------------------------------------------------
package pidbc_pkg;

    // Input beat: error and measurement delta, signed Q16.16.
    typedef struct packed {
        logic signed [31:0] error_value;
        logic signed [31:0] measure_delta;
    } in_beat_t;

    // Output beat: clamped drive and saturation code.
    typedef struct packed {
        logic signed [31:0] drive_value;
        logic [1:0]         saturation;
    } out_beat_t;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P         = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I         = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D         = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_LIMIT = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_LIMIT   = 3'd6;

    // Saturation codes.
    localparam logic [1:0] SAT_NONE = 2'd0;
    localparam logic [1:0] SAT_HIGH = 2'd1;
    localparam logic [1:0] SAT_LOW  = 2'd2;

    // Divider sizing: a 34-bit magnitude shifted left by 16, over a
    // positive 31-bit gain.
    localparam int DIVIDEND_W = 50;
    localparam int DIVISOR_W  = 31;

    // Divider status seen by the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage
`default_nettype wire

### src/pidbc_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PID back-calculation unit divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pidbc_div (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    input  wire logic [pidbc_pkg::DIVIDEND_W-1:0] dividend,
    input  wire logic [pidbc_pkg::DIVISOR_W-1:0]  divisor,
    output logic      [pidbc_pkg::DIVIDEND_W-1:0] quotient,
    output pidbc_pkg::div_status_t                status
);
    import pidbc_pkg::*;

    localparam int CNT_W = $clog2(DIVIDEND_W);

    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W-1:0]  rem_next;
    logic [DIVISOR_W-1:0]  divisor_reg;
    logic [DIVIDEND_W-1:0] quo_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;
    logic [DIVISOR_W:0]    rem_shift;
    logic [DIVISOR_W:0]    rem_diff;
    logic                  take;

    // One restoring step: shift in the next dividend bit and try to subtract.
    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[DIVIDEND_W-1]};
        rem_diff  = rem_shift - {1'b0, divisor_reg};
        take      = rem_shift >= {1'b0, divisor_reg};
        rem_next  = take ? rem_diff[DIVISOR_W-1:0] : rem_shift[DIVISOR_W-1:0];
    end

    // Step counter and status.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIVIDEND_W - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    // Remainder and quotient shift register.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg     <= '0;
            quo_reg     <= dividend;
            divisor_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[DIVIDEND_W-2:0], take};
        end
    end

    assign quotient    = quo_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule
`default_nettype wire

### src/pid_backcalc_antiwindup_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PID controller with back-calculation anti-windup
// Q16.16 PID with derivative on measurement, integral clamp, output clamp
// and integral trim on saturation.
// ----------------------------------------------------------------------------
// The unit takes one input beat at a time and is stalled until that beat's
// result is loaded into the output register. A beat that needs no trim goes
// from MP through CMP and PREP to FIN; a saturating beat with a positive
// integral gain goes from PREP through DIV, where the restoring divider
// produces one quotient bit per cycle for the trim, and TRIM to FIN. The
// result is loaded later when the previous result is still stalled
// downstream. All products go through one shared 33 x 33 multiplier, one
// product per cycle. The next beat is accepted in the cycle after the result
// is loaded, even if that result is still waiting downstream. Configuration
// writes are always ready and must only be issued while the unit is idle.
module pid_backcalc_antiwindup_unit (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire pidbc_pkg::in_beat_t           in_data,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output pidbc_pkg::out_beat_t               out_data,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [pidbc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]                   cfg_data
);
    import pidbc_pkg::*;

    // Sequencer states.
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MP   = 4'd1;
    localparam logic [3:0] S_MT   = 4'd2;
    localparam logic [3:0] S_MD   = 4'd3;
    localparam logic [3:0] S_MR   = 4'd4;
    localparam logic [3:0] S_CL   = 4'd5;
    localparam logic [3:0] S_MI   = 4'd6;
    localparam logic [3:0] S_SUM  = 4'd7;
    localparam logic [3:0] S_CMP  = 4'd8;
    localparam logic [3:0] S_PREP = 4'd9;
    localparam logic [3:0] S_DIV  = 4'd10;
    localparam logic [3:0] S_TRIM = 4'd11;
    localparam logic [3:0] S_FIN  = 4'd12;

    localparam logic signed [65:0] MAX32_W = 66'sd2147483647;
    localparam logic signed [65:0] MIN32_W = -66'sd2147483648;

    // Saturate a wide signed value to 32 bits.
    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > MAX32_W)
            r = 32'sh7FFFFFFF;
        else if (v < MIN32_W)
            r = $signed(32'h80000000);
        else
            r = $signed(v[31:0]);
        return r;
    endfunction

    // Configuration registers.
    logic signed [31:0] gain_p_reg;
    logic signed [31:0] gain_i_reg;
    logic signed [31:0] gain_d_reg;
    logic [19:0]        sample_rate_reg;
    logic [31:0]        sample_period_reg;
    logic [30:0]        integral_limit_reg;
    logic [30:0]        output_limit_reg;

    // Controller state and working registers.
    logic [3:0]         state_reg;
    logic [3:0]         state_next;
    logic signed [31:0] acc_reg;
    logic signed [31:0] err_reg;
    logic signed [31:0] md_reg;
    logic signed [65:0] prod_reg;
    logic signed [31:0] p_reg;
    logic signed [31:0] t_reg;
    logic signed [31:0] d_reg;
    logic signed [31:0] iterm_reg;
    logic signed [33:0] integ_raw_reg;
    logic signed [31:0] integ_reg;
    logic signed [31:0] integ_next;
    logic signed [31:0] drive_reg;
    logic [1:0]         sat_reg;
    logic               num_neg_reg;
    logic               out_valid_reg;
    out_beat_t          out_reg;

    // Shared multiplier.
    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [65:0] prod_next;

    // Intermediate combinational values.
    logic signed [33:0] lim_i_s;
    logic signed [33:0] lim_o_s;
    logic signed [33:0] integ_clamp;
    logic signed [33:0] sum_s;
    logic signed [33:0] lim_sel;
    logic signed [33:0] num_s;
    logic [33:0]        num_mag;
    logic               trim_wanted;
    logic signed [31:0] trim_sat;
    logic signed [31:0] trim_hold;

    // Divider hookup.
    logic                  div_start;
    logic [DIVIDEND_W-1:0] div_dividend;
    logic [DIVIDEND_W-1:0] div_quotient;
    div_status_t           div_status;

    logic in_fire;
    logic out_free;

    assign in_fire  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = state_reg != S_IDLE;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Operand selection for the shared multiplier.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_MP:
            begin
                mul_a = {gain_p_reg[31], gain_p_reg};
                mul_b = {err_reg[31], err_reg};
            end
            S_MT:
            begin
                mul_a = {gain_d_reg[31], gain_d_reg};
                mul_b = {md_reg[31], md_reg};
            end
            S_MD:
            begin
                mul_a = {err_reg[31], err_reg};
                mul_b = $signed({1'b0, sample_period_reg});
            end
            S_MR:
            begin
                mul_a = {t_reg[31], t_reg};
                mul_b = $signed({13'd0, sample_rate_reg});
            end
            S_MI:
            begin
                mul_a = {gain_i_reg[31], gain_i_reg};
                mul_b = {integ_reg[31], integ_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod_next = mul_a * mul_b;
    end

    // Clamps, sum and back-calculation numerator.
    always_comb
    begin
        lim_i_s = $signed({3'b000, integral_limit_reg});
        lim_o_s = $signed({3'b000, output_limit_reg});

        if (integ_raw_reg > lim_i_s)
            integ_clamp = lim_i_s;
        else if (integ_raw_reg < -lim_i_s)
            integ_clamp = -lim_i_s;
        else
            integ_clamp = integ_raw_reg;

        sum_s = 34'(p_reg) + 34'(iterm_reg) + 34'(d_reg);

        lim_sel = (sat_reg == SAT_HIGH) ? lim_o_s : -lim_o_s;
        num_s   = lim_sel - 34'(p_reg) - 34'(d_reg);
        num_mag = num_s[33] ? 34'(-num_s) : 34'(num_s);
        div_dividend = {num_mag, 16'd0};

        trim_wanted = (sat_reg != SAT_NONE) && !gain_i_reg[31] && (gain_i_reg != '0);
        div_start   = (state_reg == S_PREP) && trim_wanted;
    end

    // Trim value from the quotient, sign hold, and integral update.
    always_comb
    begin
        if (!num_neg_reg)
        begin
            if (div_quotient > DIVIDEND_W'(32'h7FFFFFFF))
                trim_sat = 32'sh7FFFFFFF;
            else
                trim_sat = $signed(div_quotient[31:0]);
        end
        else
        begin
            if (div_quotient >= DIVIDEND_W'(32'h80000000))
                trim_sat = $signed(32'h80000000);
            else
                trim_sat = -$signed(div_quotient[31:0]);
        end

        trim_hold = trim_sat;
        if ((sat_reg == SAT_HIGH) && (trim_sat < 0))
            trim_hold = '0;
        else if ((sat_reg == SAT_LOW) && (trim_sat > 0))
            trim_hold = '0;

        integ_next = integ_reg;
        if ((sat_reg == SAT_HIGH) && (integ_reg > trim_hold))
            integ_next = trim_hold;
        else if ((sat_reg == SAT_LOW) && (integ_reg < trim_hold))
            integ_next = trim_hold;
    end

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (in_fire) state_next = S_MP;
            S_MP:   state_next = S_MT;
            S_MT:   state_next = S_MD;
            S_MD:   state_next = S_MR;
            S_MR:   state_next = S_CL;
            S_CL:   state_next = S_MI;
            S_MI:   state_next = S_SUM;
            S_SUM:  state_next = S_CMP;
            S_CMP:  state_next = S_PREP;
            S_PREP: state_next = trim_wanted ? S_DIV : S_FIN;
            S_DIV:  if (div_status.done) state_next = S_TRIM;
            S_TRIM: state_next = S_FIN;
            S_FIN:  if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Control state, configuration, integral accumulator and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            out_valid_reg      <= 1'b0;
            acc_reg            <= '0;
            gain_p_reg         <= '0;
            gain_i_reg         <= '0;
            gain_d_reg         <= '0;
            sample_rate_reg    <= 20'd10000;
            sample_period_reg  <= 32'd429497;
            integral_limit_reg <= '0;
            output_limit_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;

            if ((state_reg == S_FIN) && out_free)
            begin
                out_valid_reg <= 1'b1;
                acc_reg       <= integ_reg;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_GAIN_P:         gain_p_reg         <= $signed(cfg_data);
                    REG_GAIN_I:         gain_i_reg         <= $signed(cfg_data);
                    REG_GAIN_D:         gain_d_reg         <= $signed(cfg_data);
                    REG_SAMPLE_RATE:    sample_rate_reg    <= cfg_data[19:0];
                    REG_SAMPLE_PERIOD:  sample_period_reg  <= cfg_data;
                    REG_INTEGRAL_LIMIT: integral_limit_reg <= cfg_data[30:0];
                    REG_OUTPUT_LIMIT:   output_limit_reg   <= cfg_data[30:0];
                    default:            ;
                endcase
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;

        if (in_fire)
        begin
            err_reg <= in_data.error_value;
            md_reg  <= in_data.measure_delta;
        end

        case (state_reg)
            S_MT:   p_reg <= sat32(prod_reg >>> 16);
            S_MD:   t_reg <= sat32(prod_reg >>> 16);
            S_MR:   integ_raw_reg <= 34'(acc_reg) + $signed(prod_reg[65:32]);
            S_CL:
            begin
                d_reg     <= sat32(prod_reg);
                integ_reg <= integ_clamp[31:0];
            end
            S_SUM:  iterm_reg <= sat32(prod_reg >>> 16);
            S_CMP:
            begin
                if (sum_s > lim_o_s)
                begin
                    sat_reg   <= SAT_HIGH;
                    drive_reg <= lim_o_s[31:0];
                end
                else if (sum_s < -lim_o_s)
                begin
                    sat_reg   <= SAT_LOW;
                    drive_reg <= 32'(-lim_o_s);
                end
                else
                begin
                    sat_reg   <= SAT_NONE;
                    drive_reg <= sum_s[31:0];
                end
            end
            S_PREP: num_neg_reg <= num_s[33];
            S_TRIM: integ_reg <= integ_next;
            default: ;
        endcase

        if ((state_reg == S_FIN) && out_free)
        begin
            out_reg.drive_value <= drive_reg;
            out_reg.saturation  <= sat_reg;
        end
    end

    pidbc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (gain_i_reg[DIVISOR_W-1:0]),
        .quotient (div_quotient),
        .status   (div_status)
    );

    // The divider only finishes while the sequencer waits for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_status.done |-> state_reg == S_DIV)
        else $error("divider finished outside the divide wait");

    // A trim only starts on a saturated beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> (sat_reg == SAT_HIGH || sat_reg == SAT_LOW) && !div_status.busy)
        else $error("divider started without saturation or while busy");

    // A delivered drive lies within the output limit.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ($signed(out_data.drive_value) <= $signed({1'b0, output_limit_reg}))
            && ($signed(out_data.drive_value) >= -$signed({1'b0, output_limit_reg})))
        else $error("drive beyond output limit");

    // A high clamp drives exactly the positive limit.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.saturation == SAT_HIGH)
            |-> $signed(out_data.drive_value) == $signed({1'b0, output_limit_reg}))
        else $error("high clamp does not drive the limit");

endmodule
`default_nettype wire

### sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PID back-calculation unit testbench
// Drives error and measurement-delta beats into the controller under random
// idle and stall. It predicts each drive value, saturation code and integral
// update in Q16.16, and checks every result beat against the oldest
// prediction. Directed cases cover field extremes, both clamp directions,
// the trim and its suppression, a zero rate, a zero output limit and
// ignored register bits. Random phases follow, with reconfiguration between
// them.
// ----------------------------------------------------------------------------
module tb;
    import pidbc_pkg::*;

    // Index past the last register; writes to it must be ignored.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;
    localparam int IDLE_PCT      = 26;
    localparam int HOLD_LEN      = 400;
    localparam int SETTLE_CYCLES = 100;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    in_beat_t             in_data;
    logic                 out_valid;
    logic                 out_stall;
    out_beat_t            out_data;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [31:0]          cfg_data;

    // Predictor copy of the registers and of the integral.
    longint kp        = 0;
    longint ki        = 0;
    longint kd        = 0;
    longint rate      = 10000;
    longint period    = 429497;
    longint int_limit = 0;
    longint out_limit = 0;
    longint integral  = 0;

    out_beat_t pending_drives[$];
    int        fail_count    = 0;
    bit        no_idle       = 1'b0;
    int        hold_requests = 0;

    pid_backcalc_antiwindup_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Saturate to the signed 32-bit range.
    function automatic longint clip32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // Mirror a register write, dropping bits above each register's width.
    function automatic void store_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
        case (idx)
            REG_GAIN_P:         kp        = longint'($signed(value));
            REG_GAIN_I:         ki        = longint'($signed(value));
            REG_GAIN_D:         kd        = longint'($signed(value));
            REG_SAMPLE_RATE:    rate      = longint'(value[19:0]);
            REG_SAMPLE_PERIOD:  period    = longint'(value);
            REG_INTEGRAL_LIMIT: int_limit = longint'(value[30:0]);
            REG_OUTPUT_LIMIT:   out_limit = longint'(value[30:0]);
            default: ;
        endcase
    endfunction

    // Compute one controller update and advance the predicted integral.
    function automatic out_beat_t predict_drive(logic [31:0] err_bits, logic [31:0] md_bits);
        longint    e;
        longint    m;
        longint    p;
        longint    t;
        longint    d;
        longint    integ;
        longint    sum;
        longint    drive;
        longint    trim;
        out_beat_t res;
        e = longint'($signed(err_bits));
        m = longint'($signed(md_bits));
        p = clip32((kp * e) >>> 16);
        t = clip32((kd * m) >>> 16);
        d = clip32(t * rate);

        integ = integral + ((e * period) >>> 32);
        if (integ > int_limit)
            integ = int_limit;
        else if (integ < -int_limit)
            integ = -int_limit;

        sum = p + clip32((ki * integ) >>> 16) + d;
        drive = sum;
        res.saturation = SAT_NONE;

        // On a clamp with a positive integral gain, back-calculate the integral toward the limit.
        if (sum > out_limit)
        begin
            drive = out_limit;
            res.saturation = SAT_HIGH;
            if (ki > 0)
            begin
                trim = clip32(((out_limit - p - d) * 65536) / ki);
                if (trim < 0)
                    trim = 0;
                if (integ > trim)
                    integ = trim;
            end
        end
        else if (sum < -out_limit)
        begin
            drive = -out_limit;
            res.saturation = SAT_LOW;
            if (ki > 0)
            begin
                trim = clip32(((-out_limit - p - d) * 65536) / ki);
                if (trim > 0)
                    trim = 0;
                if (integ < trim)
                    integ = trim;
            end
        end

        integral = integ;
        res.drive_value = drive[31:0];
        return res;
    endfunction

    // Receiver: random stalls, plus a long hold-off whenever one is requested.
    initial
    begin : result_receiver
        int hold_left;
        int hold_served;
        hold_left = 0;
        hold_served = 0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_served != hold_requests)
            begin
                hold_served = hold_requests;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= !no_idle && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    // Compare each accepted result beat with the oldest prediction.
    always @(posedge clk)
    begin : check_results
        out_beat_t want;
        if (rst_n === 1'b1 && out_valid && !out_stall)
        begin
            if (pending_drives.size() == 0)
            begin
                $error("unexpected result beat: drive_value %0d, saturation %0d",
                       out_data.drive_value, out_data.saturation);
                fail_count++;
            end
            else
            begin
                want = pending_drives.pop_front();
                if (out_data.drive_value !== want.drive_value)
                begin
                    $error("drive_value: expected %0d, got %0d",
                           want.drive_value, out_data.drive_value);
                    fail_count++;
                end
                if (out_data.saturation !== want.saturation)
                begin
                    $error("saturation: expected %0d, got %0d",
                           want.saturation, out_data.saturation);
                    fail_count++;
                end
            end
        end
    end

    // Offer one input beat, after an optional gap, and wait until it is taken.
    task automatic send_beat(input logic [31:0] err_bits, input logic [31:0] md_bits);
        in_beat_t beat;
        int       gap;
        if (!no_idle && $urandom_range(0, 99) < IDLE_PCT)
        begin
            gap = $urandom_range(1, 70);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        beat.error_value = err_bits;
        beat.measure_delta = md_bits;
        in_valid <= 1'b1;
        in_data <= beat;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_drives.push_back(predict_drive(err_bits, md_bits));
        @(negedge clk);
    endtask

    // Stop offering and wait until every predicted beat has come back.
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_drives.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        store_reg(idx, value);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_regs(input logic [31:0] p_gain, input logic [31:0] i_gain,
                             input logic [31:0] d_gain, input logic [31:0] rate_hz,
                             input logic [31:0] period_q, input logic [31:0] ilim,
                             input logic [31:0] olim);
        write_reg(REG_GAIN_P, p_gain);
        write_reg(REG_GAIN_I, i_gain);
        write_reg(REG_GAIN_D, d_gain);
        write_reg(REG_SAMPLE_RATE, rate_hz);
        write_reg(REG_SAMPLE_PERIOD, period_q);
        write_reg(REG_INTEGRAL_LIMIT, ilim);
        write_reg(REG_OUTPUT_LIMIT, olim);
    endtask

    // Mostly a moderate signed gain, sometimes zero or any 32-bit value.
    function automatic logic [31:0] pick_gain(int span);
        case ($urandom_range(0, 9))
            0:       return $urandom;
            1:       return 32'd0;
            default: return int'($urandom_range(0, 2 * span)) - span;
        endcase
    endfunction

    // Random register set; narrow registers get junk in their unused bits.
    task automatic randomize_regs();
        logic [31:0] i_gain;
        logic [19:0] rate_hz;
        logic [31:0] period_q;
        logic [30:0] ilim;
        logic [30:0] olim;
        if ($urandom_range(0, 9) < 7)
            i_gain = $urandom_range(1, 32'h0004_0000);
        else
            i_gain = pick_gain(32'h0004_0000);
        case ($urandom_range(0, 9))
            0:       rate_hz = 20'd0;
            1:       rate_hz = 20'd1000000;
            2:       rate_hz = 20'd1;
            default: rate_hz = 20'($urandom_range(100, 100000));
        endcase
        if (rate_hz == 20'd1)
            period_q = 32'hFFFF_FFFF;
        else if (rate_hz != 20'd0 && $urandom_range(0, 9) < 8)
            period_q = 32'(64'h1_0000_0000 / rate_hz);
        else
            period_q = $urandom;
        case ($urandom_range(0, 9))
            0:       ilim = 31'd0;
            1:       ilim = 31'h7FFF_FFFF;
            default: ilim = 31'($urandom_range(32'h1000, 32'h40_0000));
        endcase
        case ($urandom_range(0, 9))
            0:       olim = 31'd0;
            1:       olim = 31'h7FFF_FFFF;
            default: olim = 31'($urandom_range(32'h1000, 32'h20_0000));
        endcase
        load_regs(pick_gain(32'h0004_0000), i_gain, pick_gain(32'h0400),
                  ($urandom & 32'hFFF0_0000) | 32'(rate_hz), period_q,
                  {1'($urandom_range(0, 1)), ilim}, {1'($urandom_range(0, 1)), olim});
    endtask

    // A run of beats around a sustained error that flips sign now and then,
    // so the integral winds up and gets trimmed in both directions.
    task automatic send_run(input int count);
        int bias;
        int err;
        int md;
        bias = int'($urandom_range(0, 32'h6_0000));
        if ($urandom_range(0, 1))
            bias = -bias;
        for (int n = 0; n < count; n++)
        begin
            if (n % 30 == 29 && $urandom_range(0, 1))
                bias = -bias;
            if ($urandom_range(0, 9) < 2)
            begin
                err = $urandom;
                md = $urandom;
            end
            else
            begin
                err = bias + int'($urandom_range(0, 32'h1_0000)) - 32'h8000;
                md = int'($urandom_range(0, 32'h2000)) - 32'h1000;
            end
            send_beat(err, md);
        end
    endtask

    // Reset values: zero gains and a zero output limit pin the drive at zero.
    task automatic test_reset_state();
        send_beat(32'h0000_0000, 32'h0000_0000);
        send_beat(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_beat(32'h8000_0000, 32'h8000_0000);
        send_beat(32'h0000_0001, 32'hFFFF_FFFF);
        drain();
    endtask

    task automatic test_directed_cases();
        // Nominal gains, both clamps with trim, and a little windup.
        load_regs(32'h0001_0000, 32'h0000_8000, 32'h0000_0100, 32'd1000,
                  32'd4294967, 32'h0010_0000, 32'h0002_0000);
        send_beat(32'h0000_0000, 32'h0000_0000);
        send_beat(32'h0001_0000, 32'h0000_0000);
        send_beat(32'h7FFF_FFFF, 32'h0000_0000);
        send_beat(32'h8000_0000, 32'h0000_0000);
        send_beat(32'h0000_0000, 32'h7FFF_FFFF);
        send_beat(32'h0000_0000, 32'h8000_0000);
        repeat (3) send_beat(32'h0004_0000, 32'h0000_0000);
        drain();

        // Negative and zero integral gain: clamps happen but nothing is trimmed.
        write_reg(REG_GAIN_I, 32'hFFFF_0000);
        send_beat(32'h7FFF_FFFF, 32'h0000_0000);
        send_beat(32'h8000_0000, 32'h0000_0000);
        drain();
        write_reg(REG_GAIN_I, 32'h0000_0000);
        send_beat(32'h7FFF_FFFF, 32'h0000_0000);
        drain();

        // A rate whose low 20 bits are zero kills the D term.
        write_reg(REG_SAMPLE_RATE, 32'hFFF0_0000);
        send_beat(32'h0000_0000, 32'h7FFF_FFFF);
        drain();

        // A write past the last register changes nothing.
        write_reg(REG_SPARE, 32'hFFFF_FFFF);
        send_beat(32'h0001_0000, 32'h0001_0000);
        drain();

        // Zero output limit (top bit ignored): any nonzero sum clamps to zero.
        write_reg(REG_GAIN_I, 32'h0000_8000);
        write_reg(REG_OUTPUT_LIMIT, 32'h8000_0000);
        send_beat(32'h0000_0000, 32'h0000_0000);
        send_beat(32'h0001_0000, 32'h0000_0000);
        send_beat(32'hFFFF_0000, 32'h0000_0000);
        drain();

        // Register extremes, where intermediate terms saturate.
        load_regs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                  32'hFFF0_0000 | 32'd1000000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  32'h7FFF_FFFF);
        send_beat(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_beat(32'h8000_0000, 32'h8000_0000);
        send_beat(32'h7FFF_FFFF, 32'h8000_0000);
        send_beat(32'h8000_0000, 32'h7FFF_FFFF);
        drain();
        write_reg(REG_SAMPLE_RATE, 32'd1);
        send_beat(32'h0000_0001, 32'h7FFF_FFFF);
        drain();
    endtask

    // The receiver holds off while beats keep coming, so the unit backs up.
    task automatic test_output_backpressure();
        randomize_regs();
        hold_requests++;
        send_run(16);
        drain();
    endtask

    task automatic test_back_to_back();
        randomize_regs();
        no_idle = 1'b1;
        send_run(120);
        drain();
        no_idle = 1'b0;
    endtask

    task automatic test_random_phases();
        for (int phase = 0; phase < 16; phase++)
        begin
            randomize_regs();
            send_run(110);
            drain();
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_state();
        test_directed_cases();
        test_output_backpressure();
        test_back_to_back();
        test_random_phases();

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #4ms;
        $display("FAIL");
        $finish;
    end

endmodule
